// ===== design/lrb_pkg.sv =====
// shared constants and controller/datapath handshake types for the line rasterizer
`timescale 1ns / 1ps
package lrb_pkg;

  localparam int COORD_BITS_DEF = 6;
  localparam int COLOR_BITS     = 24;

  // controller to datapath
  typedef struct packed {
    logic load;   // capture the incoming command word
    logic setup;  // order endpoints and prime the stepper
    logic emit;   // write current pixel to output register and step
  } lrb_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic at_last;  // stepper sits on the final major coordinate
  } lrb_sts_t;

endpackage

// ===== design/lrb_cmd_if.sv =====
// line command channel: two endpoints and a color
`timescale 1ns / 1ps
interface lrb_cmd_if #(
  parameter int COORD_BITS = lrb_pkg::COORD_BITS_DEF
);
  import lrb_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] start_x;
  logic [COORD_BITS-1:0] start_y;
  logic [COORD_BITS-1:0] end_x;
  logic [COORD_BITS-1:0] end_y;
  logic [COLOR_BITS-1:0] line_color;

  modport source (output valid, start_x, start_y, end_x, end_y, line_color, input ready);
  modport sink   (input valid, start_x, start_y, end_x, end_y, line_color, output ready);
endinterface

// ===== design/lrb_pix_if.sv =====
// pixel result channel
`timescale 1ns / 1ps
interface lrb_pix_if #(
  parameter int COORD_BITS = lrb_pkg::COORD_BITS_DEF
);
  import lrb_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] pixel_x;
  logic [COORD_BITS-1:0] pixel_y;
  logic [COLOR_BITS-1:0] pixel_color;
  logic                  last_pixel;

  modport source (output valid, pixel_x, pixel_y, pixel_color, last_pixel, input ready);
  modport sink   (input valid, pixel_x, pixel_y, pixel_color, last_pixel, output ready);
endinterface

// ===== design/lrb_ctrl.sv =====
// controller: command sequencing and output word valid
`timescale 1ns / 1ps
module lrb_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  output lrb_pkg::lrb_cmd_t cmd,
  input  lrb_pkg::lrb_sts_t sts
);
  import lrb_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SETUP,
    ST_RUN
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_SETUP;
        end
      end
      ST_SETUP: begin
        cmd.setup = 1'b1;
        state_nxt = ST_RUN;
      end
      ST_RUN: begin
        if (slot_free) begin
          cmd.emit      = 1'b1;
          out_valid_nxt = 1'b1;
          if (sts.at_last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== design/lrb_dp.sv =====
// datapath: endpoint ordering, bresenham stepper and output word register
`timescale 1ns / 1ps
module lrb_dp #(
  parameter int COORD_BITS = lrb_pkg::COORD_BITS_DEF
) (
  input  logic                          clk,
  input  lrb_pkg::lrb_cmd_t             cmd,
  output lrb_pkg::lrb_sts_t             sts,
  input  logic [COORD_BITS-1:0]         start_x,
  input  logic [COORD_BITS-1:0]         start_y,
  input  logic [COORD_BITS-1:0]         end_x,
  input  logic [COORD_BITS-1:0]         end_y,
  input  logic [lrb_pkg::COLOR_BITS-1:0] line_color,
  output logic [COORD_BITS-1:0]         pixel_x,
  output logic [COORD_BITS-1:0]         pixel_y,
  output logic [lrb_pkg::COLOR_BITS-1:0] pixel_color,
  output logic                          last_pixel
);
  import lrb_pkg::*;

  // error needs sign, one bit for 1.5 * d_major and one for the doubling
  localparam int EW = COORD_BITS + 3;

  logic [COORD_BITS-1:0] ax_r, ay_r, bx_r, by_r;
  logic [COLOR_BITS-1:0] color_r;

  logic                  steep_r, up_r;
  logic [COORD_BITS-1:0] mj_r, mj_end_r, mn_r, dmaj_r, dmin_r;
  logic signed [EW-1:0]  err_r;

  logic [COORD_BITS-1:0] px_r, py_r;
  logic [COLOR_BITS-1:0] pcol_r;
  logic                  plast_r;

  // setup terms
  logic [COORD_BITS-1:0] dx_abs, dy_abs;
  logic                  steep;
  logic [COORD_BITS-1:0] maj0, min0, maj1, min1;
  logic                  swap;
  logic [COORD_BITS-1:0] s_maj0, s_min0, s_maj1, s_min1;

  // step terms
  logic signed [EW-1:0]  e_sum, e_dbl, dmaj_ext;
  logic                  take;

  always_comb begin
    dx_abs = (ax_r > bx_r) ? (ax_r - bx_r) : (bx_r - ax_r);
    dy_abs = (ay_r > by_r) ? (ay_r - by_r) : (by_r - ay_r);
    steep  = dy_abs > dx_abs;
    maj0   = steep ? ay_r : ax_r;
    min0   = steep ? ax_r : ay_r;
    maj1   = steep ? by_r : bx_r;
    min1   = steep ? bx_r : by_r;
    swap   = maj0 > maj1;
    s_maj0 = swap ? maj1 : maj0;
    s_min0 = swap ? min1 : min0;
    s_maj1 = swap ? maj0 : maj1;
    s_min1 = swap ? min0 : min1;
  end

  always_comb begin
    dmaj_ext = signed'({3'b000, dmaj_r});
    e_sum    = err_r + signed'({3'b000, dmin_r});
    e_dbl    = e_sum <<< 1;
    take     = e_dbl >= dmaj_ext;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ax_r    <= start_x;
      ay_r    <= start_y;
      bx_r    <= end_x;
      by_r    <= end_y;
      color_r <= line_color;
    end
    if (cmd.setup) begin
      steep_r  <= steep;
      mj_r     <= s_maj0;
      mj_end_r <= s_maj1;
      mn_r     <= s_min0;
      dmaj_r   <= s_maj1 - s_maj0;
      dmin_r   <= steep ? dx_abs : dy_abs;
      up_r     <= s_min0 < s_min1;
      err_r    <= '0;
    end
    if (cmd.emit) begin
      px_r    <= steep_r ? mn_r : mj_r;
      py_r    <= steep_r ? mj_r : mn_r;
      pcol_r  <= color_r;
      plast_r <= (mj_r == mj_end_r);
      mj_r    <= mj_r + 1'b1;
      if (take) begin
        err_r <= e_sum - dmaj_ext;
        mn_r  <= up_r ? (mn_r + 1'b1) : (mn_r - 1'b1);
      end else begin
        err_r <= e_sum;
      end
    end
  end

  assign sts.at_last = (mj_r == mj_end_r);
  assign pixel_x     = px_r;
  assign pixel_y     = py_r;
  assign pixel_color = pcol_r;
  assign last_pixel  = plast_r;

endmodule

// ===== design/line_rasterizer_bresenham.sv =====
// top level of the bresenham line rasterizer
// One command word (two endpoints in a square tile and a 24-bit color) yields
// max(|dx|,|dy|)+1 pixel words, stepped from the endpoint with the smaller major
// coordinate, with last_pixel set on the final one. A command is accepted, then a
// setup step orders the endpoints, then the stepper emits one pixel per cycle
// while the output register is free (backpressure on out_pix stalls it). The
// stepper's single error accumulator sets this rate. The last pixel word sits in
// the output register while the next command is taken.
`timescale 1ns / 1ps
module line_rasterizer_bresenham #(
  parameter int COORD_BITS = lrb_pkg::COORD_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  lrb_cmd_if.sink   in_cmd,
  lrb_pix_if.source out_pix
);
  import lrb_pkg::*;

  lrb_cmd_t cmd;
  lrb_sts_t sts;

  lrb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_cmd.valid),
    .in_ready  (in_cmd.ready),
    .out_valid (out_pix.valid),
    .out_ready (out_pix.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  lrb_dp #(
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk         (clk),
    .cmd         (cmd),
    .sts         (sts),
    .start_x     (in_cmd.start_x),
    .start_y     (in_cmd.start_y),
    .end_x       (in_cmd.end_x),
    .end_y       (in_cmd.end_y),
    .line_color  (in_cmd.line_color),
    .pixel_x     (out_pix.pixel_x),
    .pixel_y     (out_pix.pixel_y),
    .pixel_color (out_pix.pixel_color),
    .last_pixel  (out_pix.last_pixel)
  );

endmodule
